// File: src/asac_pkg.sv
// Shared types, constants and modular helpers for the adjacent-step array counter.
// No dependencies; imported by every module of the block.
package asac_pkg;

    localparam int unsigned COUNT_W = 30;
    localparam int unsigned ELEM_W  = 8;

    localparam logic [COUNT_W-1:0] COUNT_MOD   = 30'd1000000007;
    localparam logic [31:0]        COUNT_MOD_1 = 32'd1000000007;
    localparam logic [31:0]        COUNT_MOD_2 = 32'd2000000014;
    localparam logic [ELEM_W-1:0]  BOUND_RESET = 8'd128;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } state_t;

    // One issue slot of the sweep, from the sequencer to the step unit.
    typedef struct packed {
        logic valid;   // a value index is issued this cycle
        logic start;   // first index of the element
        logic first;   // element opens a new array
        logic fetch;   // memory read is real (otherwise the old count is zero)
    } issue_t;

    // (a + b + c) mod P for a, b, c below P.
    function automatic logic [COUNT_W-1:0] sum3_mod(input logic [COUNT_W-1:0] a,
                                                    input logic [COUNT_W-1:0] b,
                                                    input logic [COUNT_W-1:0] c);
        logic [31:0] s;
        logic [31:0] r;
        s = 32'(a) + 32'(b) + 32'(c);
        if (s >= COUNT_MOD_2) begin
            r = s - COUNT_MOD_2;
        end else if (s >= COUNT_MOD_1) begin
            r = s - COUNT_MOD_1;
        end else begin
            r = s;
        end
        return r[COUNT_W-1:0];
    endfunction

    // (a + b) mod P for a, b below P.
    function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
        logic [31:0] s;
        logic [31:0] r;
        s = 32'(a) + 32'(b);
        if (s >= COUNT_MOD_1) begin
            r = s - COUNT_MOD_1;
        end else begin
            r = s;
        end
        return r[COUNT_W-1:0];
    endfunction

endpackage

// File: src/adjacent_step_array_counter.sv
// Adjacent-step array counter, top level: sequencer, bound register, result register.
// Depends on asac_pkg, asac_ways_mem and asac_step_unit.
//
// Counts, modulo 1000000007, the arrays with values in 1..m whose neighbors
// differ by at most one and that agree with every known element (element
// value 0 is unknown). Elements arrive one per input transfer; the transfer
// with s_is_last set closes the array and later yields one result transfer
// carrying m_array_count. The per-value counts live in one memory of
// MAX_VALUE entries with registered read data. Each element sweeps that
// memory once: one read-modify-write per value. After an element is
// accepted, s_ready stays low until its sweep has drained, so no new
// element is taken before the last one is through (m is upper_bound,
// saturated at MAX_VALUE). The sweep issues m + 1 indices, the extra one
// closing the read-ahead of the sliding three-count window; the read, sum
// and total stages then drain, and the next element is taken only once the
// sequencer is back in idle. A finished result waits in an output
// register while the next element is taken; only a second closing element
// stalls until the first result transfer is done. Write upper_bound through
// the cfg port only while the block is idle; its reset value is 128.
module adjacent_step_array_counter import asac_pkg::*; #(
    parameter int MAX_VALUE = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [ELEM_W-1:0]  cfg_data,
    // element input
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [ELEM_W-1:0]  s_element_value,
    input  logic               s_is_last,
    // result output
    output logic               m_valid,
    input  logic               m_ready,
    output logic [COUNT_W-1:0] m_array_count
);

    localparam int CW = $clog2(MAX_VALUE + 2);
    localparam int AW = $clog2(MAX_VALUE);
    localparam int XW = (CW > ELEM_W) ? CW : ELEM_W;

    state_t              state_reg, state_next;
    logic [ELEM_W-1:0]   bound_reg;
    logic [ELEM_W-1:0]   elem_reg;
    logic                last_reg;
    logic                first_reg;
    logic                awaiting_first_reg;
    logic [CW-1:0]       m_cur_reg;
    logic [CW-1:0]       rd_lim_reg;
    logic [CW-1:0]       idx_reg;
    logic                m_valid_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    logic [CW-1:0]       m_now;
    logic                s_take;
    logic                emit;
    logic                finish;
    issue_t              issue;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [COUNT_W-1:0]  rd_data;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COUNT_W-1:0]  wr_data;
    logic                busy;
    logic [COUNT_W-1:0]  total;

    // Bound register: always ready, write on transfer.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bound_reg <= BOUND_RESET;
        end else if (cfg_valid && cfg_ready) begin
            bound_reg <= cfg_data;
        end
    end

    // Saturate the bound at the memory depth.
    assign m_now = (XW'(bound_reg) > XW'(MAX_VALUE)) ? CW'(MAX_VALUE) : CW'(bound_reg);

    assign s_ready = (state_reg == ST_IDLE);
    assign s_take  = s_valid && s_ready;

    // Element done once the pipeline has drained; a closing element also
    // needs the result register free (or freed this cycle).
    assign finish = (state_reg == ST_FLUSH) && !busy
                 && (!last_reg || !m_valid_reg || m_ready);
    assign emit   = finish && last_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_take) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (idx_reg == m_cur_reg + CW'(1)) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (finish) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= ST_IDLE;
            awaiting_first_reg <= 1'b1;
            m_valid_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (finish) begin
                awaiting_first_reg <= last_reg;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            elem_reg   <= s_element_value;
            last_reg   <= s_is_last;
            first_reg  <= awaiting_first_reg;
            m_cur_reg  <= m_now;
            // Old counts exist only up to the bound of the previous element.
            rd_lim_reg <= (m_now < m_cur_reg) ? m_now : m_cur_reg;
            idx_reg    <= CW'(1);
        end else if (state_reg == ST_RUN) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (emit) begin
            m_count_reg <= total;
        end
    end

    // Issue value indices 1..m+1; the last one only closes the window.
    always_comb begin
        issue.valid = (state_reg == ST_RUN);
        issue.start = (state_reg == ST_RUN) && (idx_reg == CW'(1));
        issue.first = first_reg;
        issue.fetch = (state_reg == ST_RUN) && !first_reg && (idx_reg <= rd_lim_reg);
    end

    assign rd_en   = issue.fetch;
    assign rd_addr = AW'(idx_reg - CW'(1));

    asac_ways_mem #(
        .DEPTH (MAX_VALUE)
    ) u_ways_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    asac_step_unit #(
        .MAX_VALUE (MAX_VALUE)
    ) u_step_unit (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .issue_idx (idx_reg),
        .elem      (elem_reg),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .busy      (busy),
        .total     (total)
    );

    assign m_valid       = m_valid_reg;
    assign m_array_count = m_count_reg;

    // The read-ahead never touches the entry being written back.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write-back hit the same count entry");

    // No write-back once the sequencer is idle.
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !wr_en)
        else $error("count write while idle");

    // The first element of an array never reads old counts.
    a_first_no_fetch: assert property (@(posedge aclk) disable iff (!aresetn)
        (issue.fetch) |-> !first_reg)
        else $error("old counts fetched for the first element");

    // A result appears only after a closing element has drained.
    a_emit_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FLUSH) && last_reg)
        else $error("result without a closing element");

endmodule

// File: src/asac_ways_mem.sv
// Count memory: one write port, one read port with registered read data.
// Depends on asac_pkg for the count width.
module asac_ways_mem import asac_pkg::*; #(
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [COUNT_W-1:0]       rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [COUNT_W-1:0]       wr_data
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/asac_step_unit.sv
// Update datapath: three-tap window over old counts, modular sum, write-back
// and running total. Depends on asac_pkg.
module asac_step_unit import asac_pkg::*; #(
    parameter int MAX_VALUE = 128
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  issue_t                            issue,
    input  logic [$clog2(MAX_VALUE+2)-1:0]    issue_idx,
    input  logic [ELEM_W-1:0]                 elem,
    input  logic [COUNT_W-1:0]                rd_data,
    output logic                              wr_en,
    output logic [$clog2(MAX_VALUE)-1:0]      wr_addr,
    output logic [COUNT_W-1:0]                wr_data,
    output logic                              busy,
    output logic [COUNT_W-1:0]                total
);

    localparam int CW = $clog2(MAX_VALUE + 2);
    localparam int AW = $clog2(MAX_VALUE);
    localparam int XW = (CW > ELEM_W) ? CW : ELEM_W;

    logic               s1_valid_reg;
    logic [CW-1:0]      s1_idx_reg;
    logic               s1_fetch_reg;
    logic               s1_first_reg;
    logic [COUNT_W-1:0] w_lo_reg;
    logic [COUNT_W-1:0] w_mid_reg;
    logic               a2_valid_reg;
    logic [COUNT_W-1:0] a2_data_reg;
    logic [COUNT_W-1:0] total_reg;

    logic [COUNT_W-1:0] cur;
    logic [CW-1:0]      v;
    logic               allowed;
    logic               compute;
    logic [COUNT_W-1:0] new_count;

    // Old count of the value just read; zero past the previous bound.
    assign cur     = s1_fetch_reg ? rd_data : '0;
    assign v       = s1_idx_reg - CW'(1);
    assign allowed = (elem == '0) || (XW'(elem) == XW'(v));
    assign compute = s1_valid_reg && (s1_idx_reg >= CW'(2));

    always_comb begin
        if (!allowed) begin
            new_count = '0;
        end else if (s1_first_reg) begin
            new_count = COUNT_W'(1);
        end else begin
            new_count = sum3_mod(w_lo_reg, w_mid_reg, cur);
        end
    end

    assign wr_en   = compute;
    assign wr_addr = AW'(s1_idx_reg - CW'(2));
    assign wr_data = new_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            a2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= issue.valid;
            a2_valid_reg <= compute;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue.valid) begin
            s1_idx_reg   <= issue_idx;
            s1_fetch_reg <= issue.fetch;
            s1_first_reg <= issue.first;
        end
        // Slide the window; the count below value 1 is a zero border.
        if (issue.start) begin
            w_mid_reg <= '0;
        end else if (s1_valid_reg) begin
            w_lo_reg  <= w_mid_reg;
            w_mid_reg <= cur;
        end
        a2_data_reg <= new_count;
        if (issue.start) begin
            total_reg <= '0;
        end else if (a2_valid_reg) begin
            total_reg <= add_mod(total_reg, a2_data_reg);
        end
    end

    assign busy  = s1_valid_reg || a2_valid_reg;
    assign total = total_reg;

endmodule

// File: test/testbench.sv
// Self-checking testbench for adjacent_step_array_counter: checks the element-to-count
// sweep against an in-bench predictor under random idling. Depends on asac_pkg and the RTL.
module testbench;
    import asac_pkg::*;

    localparam int MAX_VALUE      = 128;
    localparam int SETTLE_CYCLES  = MAX_VALUE + 12;  // one full sweep plus drain
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS    = 58;
    localparam int PHASE_COUNT    = 12;
    localparam int PRESSURE_PHASE = 5;
    localparam int MAX_REPORTS    = 40;

    // Bound per random phase; covers zero, one, the reset value and saturation.
    localparam logic [ELEM_W-1:0] PHASE_BOUNDS [PHASE_COUNT] =
        '{8'd128, 8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd64, 8'd129, 8'd17, 8'd128, 8'd5, 8'd100};

    typedef struct {
        logic [ELEM_W-1:0] value;
        logic              last;
    } element_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [ELEM_W-1:0]  cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [ELEM_W-1:0]  s_element_value = '0;
    logic               s_is_last = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [COUNT_W-1:0] m_array_count;

    adjacent_step_array_counter #(
        .MAX_VALUE(MAX_VALUE)
    ) u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_value(s_element_value),
        .s_is_last      (s_is_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_array_count  (m_array_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Stimulus and expectations.
    element_t           element_queue[$];
    logic [COUNT_W-1:0] pending_counts[$];
    element_t           next_element;
    logic               element_taken = 1'b0;
    int unsigned        sender_idle_pct = 0;
    int unsigned        receiver_stall_pct = 0;
    int unsigned        mismatch_count = 0;
    int unsigned        quiet_cycles = 0;

    // Predictor state: count per value with zero borders, the bound, and the array-open flag.
    logic [COUNT_W-1:0] ways_now  [0:MAX_VALUE+1] = '{default: '0};
    logic [COUNT_W-1:0] ways_prior[0:MAX_VALUE+1] = '{default: '0};
    logic [ELEM_W-1:0]  bound_reg = BOUND_RESET;
    bit                 opens_array = 1'b1;

    // Advance the per-value counts by one element; return 1 and the total when it closes the array.
    function automatic bit step_counts(input logic [ELEM_W-1:0] value, input logic last,
                                       output logic [COUNT_W-1:0] total);
        int unsigned     m;
        longint unsigned sum;
        m = (bound_reg > MAX_VALUE) ? MAX_VALUE : bound_reg;
        ways_prior = ways_now;
        // Entries above the bound in force are neither read nor summed.
        ways_prior[0]   = '0;
        ways_prior[m+1] = '0;
        for (int v = 0; v <= MAX_VALUE + 1; v++) ways_now[v] = '0;
        for (int v = 1; v <= m; v++) begin
            if (value == 0 || value == v) begin
                if (opens_array) begin
                    ways_now[v] = COUNT_W'(1);
                end else begin
                    sum = longint'(ways_prior[v-1]) + longint'(ways_prior[v])
                        + longint'(ways_prior[v+1]);
                    ways_now[v] = COUNT_W'(sum % longint'(COUNT_MOD));
                end
            end
        end
        opens_array = last;
        total = '0;
        if (!last) return 1'b0;
        sum = 0;
        for (int v = 1; v <= m; v++) sum = (sum + ways_now[v]) % longint'(COUNT_MOD);
        total = COUNT_W'(sum);
        return 1'b1;
    endfunction

    // Element driver: hold the payload until the transfer, then pick the next or idle.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || element_taken) begin
            if (element_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                next_element = element_queue.pop_front();
                s_valid         <= 1'b1;
                s_element_value <= next_element.value;
                s_is_last       <= next_element.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall at random as the phase asks.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Monitor: update the predictor on every transfer, check results, run the watchdog.
    always @(posedge aclk) begin
        logic [COUNT_W-1:0] predicted;
        logic [COUNT_W-1:0] wanted;
        element_taken <= s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                bound_reg = cfg_data;
            end
            if (s_valid && s_ready) begin
                if (step_counts(s_element_value, s_is_last, predicted)) begin
                    pending_counts.push_back(predicted);
                end
            end
            if (m_valid && m_ready) begin
                if (pending_counts.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("%0t: unexpected result: expected none, actual %0d",
                                 $time, m_array_count);
                    end
                end else begin
                    wanted = pending_counts.pop_front();
                    if (m_array_count !== wanted) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("%0t: array_count mismatch: expected %0d, actual %0d",
                                     $time, wanted, m_array_count);
                        end
                    end
                end
            end
            // Stop once the report budget is spent.
            if (mismatch_count > MAX_REPORTS) begin
                $display("RESULT: ERROR");
                $finish;
            end
            // Drop the run if nothing moves on any channel for too long.
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: watchdog expired with %0d results outstanding",
                             $time, pending_counts.size());
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    task automatic push_element(input logic [ELEM_W-1:0] value, input logic last);
        element_t item;
        item.value = value;
        item.last  = last;
        element_queue.push_back(item);
    endtask

    // Queue one array as a random walk within the bound: mostly unknown elements,
    // known values that follow the walk, and some arbitrary values as noise.
    task automatic queue_array(input int length, input logic [ELEM_W-1:0] bound,
                               input bit close);
        int          span;
        int          walk;
        int unsigned roll;
        span = (bound == 0) ? 1 : ((bound > MAX_VALUE) ? MAX_VALUE : int'(bound));
        walk = $urandom_range(span, 1);
        for (int i = 0; i < length; i++) begin
            roll = $urandom_range(99);
            walk = walk + int'($urandom_range(2)) - 1;
            if (walk < 1) walk = 1;
            if (walk > span) walk = span;
            if (roll < 60) begin
                push_element('0, close && (i == length - 1));
            end else if (roll < 90) begin
                push_element(ELEM_W'(walk), close && (i == length - 1));
            end else begin
                push_element(ELEM_W'($urandom_range(255)), close && (i == length - 1));
            end
        end
    endtask

    // Hold until every element is sent and every expected count has come back.
    task automatic wait_drained();
        while (element_queue.size() != 0 || s_valid || pending_counts.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_bound(input logic [ELEM_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          queued;
        int unsigned roll;
        int          length;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed arrays at the reset bound; the first sweep writes every count entry.
        push_element(8'd0,   1'b1);
        push_element(8'd1,   1'b1);
        push_element(8'd128, 1'b1);
        push_element(8'd129, 1'b1);
        push_element(8'd255, 1'b1);
        push_element(8'd0,   1'b0);
        push_element(8'd0,   1'b0);
        push_element(8'd0,   1'b1);
        push_element(8'd1,   1'b0);
        push_element(8'd0,   1'b0);
        push_element(8'd1,   1'b1);
        push_element(8'd128, 1'b0);
        push_element(8'd127, 1'b0);
        push_element(8'd128, 1'b1);
        push_element(8'd5,   1'b0);
        push_element(8'd7,   1'b1);
        push_element(8'd0,   1'b0);
        push_element(8'd200, 1'b0);
        push_element(8'd0,   1'b1);
        push_element(8'd64,  1'b0);
        push_element(8'd0,   1'b0);
        push_element(8'd0,   1'b0);
        push_element(8'd0,   1'b1);

        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            // Let any open element finish its sweep before touching the bound.
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge aclk);
            write_bound(PHASE_BOUNDS[phase]);
            case (phase % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
                default: begin sender_idle_pct = 22; receiver_stall_pct = 22; end
            endcase
            queued = 0;
            while (queued < PHASE_ITEMS) begin
                if (phase == PRESSURE_PHASE && queued >= PHASE_ITEMS / 2
                        && queued < PHASE_ITEMS / 2 + 4) begin
                    wait_drained();
                    queued = PHASE_ITEMS / 2 + 4;
                end
                roll = $urandom_range(99);
                if (roll < 50) begin
                    length = $urandom_range(4, 1);
                end else if (roll < 85) begin
                    length = $urandom_range(16, 5);
                end else begin
                    length = $urandom_range(48, 17);
                end
                queue_array(length, PHASE_BOUNDS[phase], 1'b1);
                queued += length;
            end
            // Leave an array open so the next bound applies in the middle of it.
            if (phase % 3 == 1 && phase != PHASE_COUNT - 1) begin
                queue_array($urandom_range(6, 1), PHASE_BOUNDS[phase], 1'b0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/asac_pkg.sv
src/asac_ways_mem.sv
src/asac_step_unit.sv
src/adjacent_step_array_counter.sv
test/testbench.sv
